FILE: src/per_pkg.sv
// palette entry recolour: shared types, constants and tables
// no dependencies; used by every module of the block
package per_pkg;

	// field and datapath widths
	localparam int CHAN_W      = 8;
	localparam int LEVEL_W     = 7;
	localparam int COUNT_W     = 9;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 9;
	localparam int REM_W       = 18;
	localparam int QUO_BITS    = 8;
	localparam int DV_W        = REM_W + QUO_BITS - 1;
	localparam int LANES       = 3;
	localparam int THR_W       = 19;

	localparam int PALETTE_SIZE   = 256;
	localparam int CONTOUR_HUES   = 10;
	localparam int CONTOUR_SPAN   = 195076;
	localparam int FULL           = 255;
	localparam int LEVEL_ENTRIES  = 1 << LEVEL_W;

	// reciprocal for the mod of the contour bin number (exact below 256)
	localparam int CONTOUR_RECIP  = (4096 + CONTOUR_HUES - 1) / CONTOUR_HUES;
	// reciprocal for division by 100, exact for every dividend here
	localparam int DIV100_RECIP   = 167773;

	// mode codes
	localparam logic [2:0] MODE_BW      = 3'd0;
	localparam logic [2:0] MODE_GRAY    = 3'd1;
	localparam logic [2:0] MODE_COLOR   = 3'd2;
	localparam logic [2:0] MODE_CUTOFF  = 3'd3;
	localparam logic [2:0] MODE_CONTOUR = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_LEVEL    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LEVEL  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LEVEL   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_DIVIDE   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_DIVIDE = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_DIVIDE  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 4'd7;

	typedef struct packed {
		logic [CHAN_W-1:0] entry_index;
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
	} in_beat_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} out_beat_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
		logic               red_divide;
		logic               green_divide;
		logic               blue_divide;
		logic [COUNT_W-1:0] entry_count;
	} cfg_t;

	// one restoring-division lane
	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [DV_W-1:0]     dv;
		logic [QUO_BITS-1:0] quo;
	} div_lane_t;

	typedef div_lane_t [LANES-1:0] div_lanes_t;

	// sideband carried alongside the division lanes
	typedef struct packed {
		logic [LANES-1:0][CHAN_W-1:0] pass_rgb;
		logic [LANES-1:0]             use_div;
		logic [LANES-1:0]             ovf;
		logic                         contour;
	} side_t;

	typedef logic [LEVEL_ENTRIES-1:0][REM_W-1:0] bin_tab_t;
	typedef logic [LEVEL_ENTRIES-1:0][THR_W-1:0] thr_tab_t;

	// contour bin width per level, worked out at elaboration
	function automatic bin_tab_t build_bin_tab();
		bin_tab_t         tab;
		int               n;
		int               rem;
		logic [REM_W-1:0] quo;
		for (int i = 0; i < LEVEL_ENTRIES; i++) begin
			n   = (i > 1) ? i : 1;
			rem = CONTOUR_SPAN;
			quo = '0;
			// long division, one quotient bit per pass
			for (int b = REM_W - 1; b >= 0; b--) begin
				if ((rem >> b) >= n) begin
					rem    = rem - (n << b);
					quo[b] = 1'b1;
				end
			end
			tab[i] = quo;
		end
		return tab;
	endfunction

	// black/white threshold 3*t*t with t = level*255/100
	function automatic thr_tab_t build_thr_tab();
		thr_tab_t tab;
		int       t;
		for (int i = 0; i < LEVEL_ENTRIES; i++) begin
			t = (i * FULL) / 100;
			tab[i] = THR_W'(3 * t * t);
		end
		return tab;
	endfunction

	localparam bin_tab_t BIN_TAB = build_bin_tab();
	localparam thr_tab_t THR_TAB = build_thr_tab();

	// divide by 100 through a reciprocal multiply
	function automatic logic [9:0] div100(input logic [16:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(DIV100_RECIP);
		return p[33:24];
	endfunction

	function automatic logic [CHAN_W-1:0] clamp8(input logic [9:0] v);
		return (v > 10'(FULL)) ? CHAN_W'(FULL) : v[CHAN_W-1:0];
	endfunction

	// fixed contour colour table, entries past the tenth are black
	function automatic out_beat_t contour_rgb(input logic [3:0] k);
		out_beat_t c;
		unique case (k)
			4'd1:    c = '{8'd0,   8'd0,   8'd255};
			4'd2:    c = '{8'd139, 8'd0,   8'd139};
			4'd3:    c = '{8'd93,  8'd71,  8'd139};
			4'd4:    c = '{8'd0,   8'd154, 8'd205};
			4'd5:    c = '{8'd50,  8'd205, 8'd50};
			4'd6:    c = '{8'd238, 8'd154, 8'd73};
			4'd7:    c = '{8'd205, 8'd201, 8'd165};
			4'd8:    c = '{8'd255, 8'd255, 8'd0};
			4'd9:    c = '{8'd255, 8'd255, 8'd255};
			default: c = '{8'd0,   8'd0,   8'd0};
		endcase
		return c;
	endfunction

endpackage

FILE: src/per_front.sv
// palette entry recolour: front stages, products, compares and divider set-up
// depends on per_pkg
module per_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  per_pkg::in_beat_t  in_beat,
	input  per_pkg::cfg_t      cfg,
	output logic               out_valid,
	output per_pkg::div_lanes_t out_lanes,
	output per_pkg::side_t     out_side
);

	logic                          valid_s1;
	per_pkg::in_beat_t             beat_s1;
	logic [15:0]                   sq_r_s1, sq_g_s1, sq_b_s1;
	logic [14:0]                   prod_r_s1, prod_g_s1, prod_b_s1;
	logic [15:0]                   cutp_s1;

	logic                          valid_s2;
	per_pkg::div_lanes_t           lanes_s2;
	per_pkg::side_t                side_s2;

	logic [per_pkg::REM_W-1:0]     sumsq;
	logic [16:0]                   gray_sum;
	logic [per_pkg::CHAN_W-1:0]    gray8, cm_r, cm_g, cm_b;
	logic                          bw_white, cut_pass;
	logic [8:0]                    idx_inc;
	logic [15:0]                   cut_lhs;
	logic [per_pkg::LANES-1:0][per_pkg::REM_W-1:0] lane_d, lane_v;
	per_pkg::div_lanes_t           lanes_d;
	per_pkg::side_t                side_d;
	logic [per_pkg::CHAN_W-1:0]    bw_val;

	// stage 1 and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1 products
	always_ff @(posedge clk) begin
		if (en) begin
			beat_s1   <= in_beat;
			sq_r_s1   <= 16'(in_beat.in_red) * 16'(in_beat.in_red);
			sq_g_s1   <= 16'(in_beat.in_green) * 16'(in_beat.in_green);
			sq_b_s1   <= 16'(in_beat.in_blue) * 16'(in_beat.in_blue);
			prod_r_s1 <= 15'(in_beat.in_red) * 15'(cfg.red_level);
			prod_g_s1 <= 15'(in_beat.in_green) * 15'(cfg.green_level);
			prod_b_s1 <= 15'(in_beat.in_blue) * 15'(cfg.blue_level);
			cutp_s1   <= 16'(cfg.entry_count) * 16'(cfg.red_level);
		end
	end

	// stage 2 sums, scaling and compares
	always_comb begin
		sumsq    = per_pkg::REM_W'(sq_r_s1) + per_pkg::REM_W'(sq_g_s1)
		         + per_pkg::REM_W'(sq_b_s1);
		gray_sum = 17'(prod_r_s1) + 17'(prod_g_s1) + 17'(prod_b_s1);
		gray8    = per_pkg::clamp8(per_pkg::div100(gray_sum));
		cm_r     = per_pkg::clamp8(per_pkg::div100(17'(prod_r_s1)));
		cm_g     = per_pkg::clamp8(per_pkg::div100(17'(prod_g_s1)));
		cm_b     = per_pkg::clamp8(per_pkg::div100(17'(prod_b_s1)));
		bw_white = per_pkg::THR_TAB[cfg.red_level] < per_pkg::THR_W'(sumsq);
		bw_val   = bw_white ? per_pkg::CHAN_W'(per_pkg::FULL) : '0;
		// index below floor(p/100) is the same as (index+1)*100 <= p
		idx_inc  = 9'(beat_s1.entry_index) + 9'd1;
		cut_lhs  = 16'(idx_inc) * 16'd100;
		cut_pass = cut_lhs <= cutp_s1;
	end

	// divider operands and per-mode sideband
	always_comb begin
		lane_d[2] = per_pkg::REM_W'(beat_s1.in_red) * per_pkg::REM_W'(100);
		lane_d[1] = per_pkg::REM_W'(beat_s1.in_green) * per_pkg::REM_W'(100);
		lane_d[0] = per_pkg::REM_W'(beat_s1.in_blue) * per_pkg::REM_W'(100);
		lane_v[2] = per_pkg::REM_W'(cfg.red_level);
		lane_v[1] = per_pkg::REM_W'(cfg.green_level);
		lane_v[0] = per_pkg::REM_W'(cfg.blue_level);

		side_d.pass_rgb = {beat_s1.in_red, beat_s1.in_green, beat_s1.in_blue};
		side_d.use_div  = '0;
		side_d.contour  = 1'b0;

		unique case (cfg.mode)
			per_pkg::MODE_BW:      side_d.pass_rgb = {bw_val, bw_val, bw_val};
			per_pkg::MODE_GRAY:    side_d.pass_rgb = {gray8, gray8, gray8};
			per_pkg::MODE_COLOR: begin
				side_d.pass_rgb = {cm_r, cm_g, cm_b};
				side_d.use_div  = {cfg.red_divide, cfg.green_divide, cfg.blue_divide};
			end
			per_pkg::MODE_CUTOFF: begin
				if (!cut_pass)
					side_d.pass_rgb = '0;
			end
			per_pkg::MODE_CONTOUR: begin
				side_d.contour = 1'b1;
				lane_d[0]      = sumsq;
				lane_v[0]      = per_pkg::BIN_TAB[cfg.red_level];
			end
			default: ;
		endcase

		for (int i = 0; i < per_pkg::LANES; i++) begin
			side_d.ovf[i]  = (lane_d[i] >> per_pkg::QUO_BITS) >= lane_v[i];
			lanes_d[i].rem = lane_d[i];
			lanes_d[i].dv  = per_pkg::DV_W'(lane_v[i]) << (per_pkg::QUO_BITS - 1);
			lanes_d[i].quo = '0;
		end
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s2 <= lanes_d;
			side_s2  <= side_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_lanes = lanes_s2;
	assign out_side  = side_s2;

endmodule

FILE: src/per_cell.sv
// palette entry recolour: one restoring division step on every lane
// depends on per_pkg
module per_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  per_pkg::div_lanes_t in_lanes,
	input  per_pkg::side_t      in_side,
	output logic                out_valid,
	output per_pkg::div_lanes_t out_lanes,
	output per_pkg::side_t      out_side
);

	logic                valid_q;
	per_pkg::div_lanes_t lanes_q;
	per_pkg::side_t      side_q;
	per_pkg::div_lanes_t step;

	// compare, subtract, shift in one quotient bit
	always_comb begin
		for (int i = 0; i < per_pkg::LANES; i++) begin
			step[i].dv = in_lanes[i].dv >> 1;
			if (per_pkg::DV_W'(in_lanes[i].rem) >= in_lanes[i].dv) begin
				step[i].rem = in_lanes[i].rem - in_lanes[i].dv[per_pkg::REM_W-1:0];
				step[i].quo = {in_lanes[i].quo[per_pkg::QUO_BITS-2:0], 1'b1};
			end else begin
				step[i].rem = in_lanes[i].rem;
				step[i].quo = {in_lanes[i].quo[per_pkg::QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_q <= step;
			side_q  <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_lanes = lanes_q;
	assign out_side  = side_q;

endmodule

FILE: src/per_obuf.sv
// palette entry recolour: two-entry output buffer parting pipeline and consumer
// depends on per_pkg
module per_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  per_pkg::out_beat_t push_beat,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output per_pkg::out_beat_t out_beat
);

	per_pkg::out_beat_t mem [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               pop;

	assign pop       = (cnt_q != 2'd0) && !out_stall;
	assign out_valid = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign out_beat  = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_beat;
	end

endmodule

FILE: src/palette_entry_recolor_top.sv
// palette entry recolour top: config registers, front stages, divider cell row
// a beat passes front stages 1 and 2, the eight division cells, then the output buffer
// throughput: one beat per cycle unless stalled, set by the cell row and front stages
// in_stall rises only when the two-entry output buffer is full
// reset: registers to their defaults, pipeline and output buffer emptied at once
// depends on per_pkg, per_front, per_cell, per_obuf
module palette_entry_recolor_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  per_pkg::in_beat_t                  in_beat,
	output logic                               out_valid,
	input  logic                               out_stall,
	output per_pkg::out_beat_t                 out_beat,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [per_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [per_pkg::CFG_DATA_W-1:0]     cfg_data
);

	per_pkg::cfg_t       cfg_q;
	logic                en, full, push;
	logic                front_valid;
	per_pkg::div_lanes_t front_lanes;
	per_pkg::side_t      front_side;

	logic                cell_valid [per_pkg::QUO_BITS+1];
	per_pkg::div_lanes_t cell_lanes [per_pkg::QUO_BITS+1];
	per_pkg::side_t      cell_side  [per_pkg::QUO_BITS+1];

	per_pkg::div_lanes_t last_lanes;
	per_pkg::side_t      last_side;
	logic [19:0]         mod_prod;
	logic [7:0]          mod_k;
	per_pkg::out_beat_t  res_beat;
	logic [per_pkg::LANES-1:0][per_pkg::CHAN_W-1:0] res_rgb;

	assign cfg_ready = 1'b1;
	assign en        = !full;
	assign in_stall  = full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= per_pkg::MODE_BW;
			cfg_q.red_level    <= 7'd100;
			cfg_q.green_level  <= 7'd100;
			cfg_q.blue_level   <= 7'd100;
			cfg_q.red_divide   <= 1'b0;
			cfg_q.green_divide <= 1'b0;
			cfg_q.blue_divide  <= 1'b0;
			cfg_q.entry_count  <= per_pkg::COUNT_W'(per_pkg::PALETTE_SIZE);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				per_pkg::CFG_MODE:         cfg_q.mode         <= cfg_data[2:0];
				per_pkg::CFG_RED_LEVEL:    cfg_q.red_level    <= cfg_data[6:0];
				per_pkg::CFG_GREEN_LEVEL:  cfg_q.green_level  <= cfg_data[6:0];
				per_pkg::CFG_BLUE_LEVEL:   cfg_q.blue_level   <= cfg_data[6:0];
				per_pkg::CFG_RED_DIVIDE:   cfg_q.red_divide   <= cfg_data[0];
				per_pkg::CFG_GREEN_DIVIDE: cfg_q.green_divide <= cfg_data[0];
				per_pkg::CFG_BLUE_DIVIDE:  cfg_q.blue_divide  <= cfg_data[0];
				per_pkg::CFG_ENTRY_COUNT: begin
					if (cfg_data > per_pkg::CFG_DATA_W'(per_pkg::PALETTE_SIZE))
						cfg_q.entry_count <= per_pkg::COUNT_W'(per_pkg::PALETTE_SIZE);
					else
						cfg_q.entry_count <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	per_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_beat   (in_beat),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_lanes (front_lanes),
		.out_side  (front_side)
	);

	assign cell_valid[0] = front_valid;
	assign cell_lanes[0] = front_lanes;
	assign cell_side[0]  = front_side;

	// row of division cells, one quotient bit each
	for (genvar c = 0; c < per_pkg::QUO_BITS; c++) begin : g_cell
		per_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_valid[c]),
			.in_lanes  (cell_lanes[c]),
			.in_side   (cell_side[c]),
			.out_valid (cell_valid[c+1]),
			.out_lanes (cell_lanes[c+1]),
			.out_side  (cell_side[c+1])
		);
	end

	assign last_lanes = cell_lanes[per_pkg::QUO_BITS];
	assign last_side  = cell_side[per_pkg::QUO_BITS];

	// result assembly: contour colour, per channel divide result or passed value
	always_comb begin
		mod_prod = 20'(last_lanes[0].quo) * 20'(per_pkg::CONTOUR_RECIP);
		mod_k    = last_lanes[0].quo - 8'(mod_prod[19:12] * 8'(per_pkg::CONTOUR_HUES));
		for (int i = 0; i < per_pkg::LANES; i++) begin
			if (!last_side.use_div[i])
				res_rgb[i] = last_side.pass_rgb[i];
			else if (last_side.ovf[i])
				res_rgb[i] = per_pkg::CHAN_W'(per_pkg::FULL);
			else
				res_rgb[i] = last_lanes[i].quo;
		end
		if (last_side.contour)
			res_beat = per_pkg::contour_rgb(mod_k[3:0]);
		else
			res_beat = {res_rgb[2], res_rgb[1], res_rgb[0]};
	end

	assign push = en && cell_valid[per_pkg::QUO_BITS];

	per_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (res_beat),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

`ifndef SYNTHESIS
	// contour bin numbers never reach 128
	a_contour_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid[per_pkg::QUO_BITS] && last_side.contour)
		|-> (last_lanes[0].quo[per_pkg::QUO_BITS-1] == 1'b0 && !last_side.ovf[0]))
		else $error("contour quotient out of range");

	// a full buffer always presents a beat
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output beat");

	// the buffer only empties by handing a beat over
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output beat lost");
`endif

endmodule
